// ----- src/fkx_pkg.sv -----
// shared types, constants and helpers for the fastq k-mer extractor
`timescale 1ns / 1ps
package fkx_pkg;

  // largest k supported and width of the nucleotide counters
  localparam int MAX_K      = 32;
  localparam int COUNT_BITS = 16;

  // derived widths
  localparam int WIN_W   = 2 * MAX_K;
  localparam int RUN_W   = $clog2(MAX_K + 1);
  localparam int KLEN_W  = 6;
  localparam int CHAR_W  = 8;
  localparam int STAT_W  = 3;
  localparam int OUTC_W  = 16;
  localparam int CIDX_W  = 4;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_KMER_LENGTH = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_WARN_ENABLE = CIDX_W'(1);

  // result status codes
  localparam logic [STAT_W-1:0] ST_KMER      = 3'd0;
  localparam logic [STAT_W-1:0] ST_WARN      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_HEADER = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISPLACED = 3'd3;
  localparam logic [STAT_W-1:0] ST_EOF_QUAL  = 3'd4;

  // character classes; the plain bases carry their 2-bit code
  typedef enum logic [2:0] {
    CL_A     = 3'd0,
    CL_C     = 3'd1,
    CL_G     = 3'd2,
    CL_T     = 3'd3,
    CL_DEGEN = 3'd4,
    CL_GAP   = 3'd5,
    CL_OTHER = 3'd6
  } char_class_t;

  // decoded view of one byte
  typedef struct packed {
    char_class_t cls;
    logic        visible;
    logic        is_newline;
    logic        is_at;
    logic        is_plus;
  } char_info_t;

  // one result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WIN_W-1:0]  kmer_bits;
    logic [OUTC_W-1:0] base_count;
  } result_t;

  // counter value as seen on the output, saturated to the field width
  function automatic logic [OUTC_W-1:0] out_count(input logic [COUNT_BITS-1:0] cnt);
    logic [31:0] ext;
    ext = 32'(cnt);
    return (ext > 32'h0000_FFFF) ? 16'hFFFF : ext[OUTC_W-1:0];
  endfunction

endpackage

// ----- src/fkx_classify.sv -----
// byte decoder: case folding and nucleotide class lookup
`timescale 1ns / 1ps
module fkx_classify (
  input  logic [7:0]          char_byte,
  output fkx_pkg::char_info_t info
);
  import fkx_pkg::*;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;

  logic [7:0] folded;

  always_comb begin
    // lower case folds to upper case
    if (char_byte >= CH_LOW_A && char_byte <= CH_LOW_Z) begin
      folded = char_byte - 8'h20;
    end else begin
      folded = char_byte;
    end

    case (folded)
      "A":               info.cls = CL_A;
      "C":               info.cls = CL_C;
      "G":               info.cls = CL_G;
      "T", "U":          info.cls = CL_T;
      "R", "Y", "K", "M", "S", "W",
      "B", "D", "H", "V", "N":
                         info.cls = CL_DEGEN;
      CH_DOT, CH_DASH:   info.cls = CL_GAP;
      default:           info.cls = CL_OTHER;
    endcase

    info.visible    = (char_byte >= 8'h21) && (char_byte <= 8'h7E);
    info.is_newline = (char_byte == CH_LF);
    info.is_at      = (char_byte == CH_AT);
    info.is_plus    = (char_byte == CH_PLUS);
  end

endmodule

// ----- src/fkx_parser.sv -----
// record phase tracker, k-mer window and result register
`timescale 1ns / 1ps
module fkx_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       end_of_file,
  input  fkx_pkg::char_info_t        info,
  input  logic [fkx_pkg::KLEN_W-1:0] kmer_length,
  input  logic                       warn_enable,
  input  logic                       out_ready,
  output logic                       out_valid,
  output fkx_pkg::result_t           result
);
  import fkx_pkg::*;

  typedef enum logic [2:0] {
    PH_EXPECT_HEADER,
    PH_HEADER_LINE,
    PH_SEQUENCE,
    PH_PLUS_LINE,
    PH_QUALITY
  } phase_t;

  phase_t                phase, phase_next;
  logic                  line_start, line_start_next;
  logic [WIN_W-1:0]      window, window_next;
  logic [COUNT_BITS-1:0] nuc_count, nuc_count_next;
  logic [RUN_W-1:0]      valid_run, valid_run_next;
  logic [COUNT_BITS-1:0] quality_left, quality_left_next;
  logic                  halted, halted_next;

  logic                  emit;
  logic [STAT_W-1:0]     emit_status;
  logic [WIN_W-1:0]      emit_bits;
  logic [KLEN_W-1:0]     k_clamped;
  logic [RUN_W-1:0]      k_eff;
  logic [WIN_W-1:0]      kmer_mask;
  logic [RUN_W-1:0]      run_inc;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] qual_dec;

  // k clamped into 1..MAX_K
  always_comb begin
    if (kmer_length == '0) begin
      k_clamped = KLEN_W'(1);
    end else if (kmer_length > KLEN_W'(MAX_K)) begin
      k_clamped = KLEN_W'(MAX_K);
    end else begin
      k_clamped = kmer_length;
    end
    k_eff = RUN_W'(k_clamped);
  end

  // two mask bits per base position below k
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      kmer_mask[2*i +: 2] = {2{RUN_W'(i) < k_eff}};
    end
  end

  assign run_inc   = (valid_run < k_eff) ? valid_run + RUN_W'(1) : valid_run;
  assign count_inc = (nuc_count != '1) ? nuc_count + COUNT_BITS'(1) : nuc_count;
  assign qual_dec  = (quality_left != '0) ? quality_left - COUNT_BITS'(1) : quality_left;

  always_comb begin
    phase_next        = phase;
    line_start_next   = line_start;
    window_next       = window;
    nuc_count_next    = nuc_count;
    valid_run_next    = valid_run;
    quality_left_next = quality_left;
    halted_next       = halted;
    emit              = 1'b0;
    emit_status       = ST_KMER;
    emit_bits         = '0;

    if (!halted) begin
      if (end_of_file) begin
        halted_next = 1'b1;
        if ((phase == PH_PLUS_LINE || phase == PH_QUALITY) && quality_left != '0) begin
          emit        = 1'b1;
          emit_status = ST_EOF_QUAL;
        end
      end else begin
        line_start_next = info.is_newline;
        unique case (phase)
          PH_EXPECT_HEADER: begin
            if (info.visible) begin
              if (!line_start) begin
                halted_next = 1'b1;
                emit        = 1'b1;
                emit_status = ST_MISPLACED;
              end else if (!info.is_at) begin
                halted_next = 1'b1;
                emit        = 1'b1;
                emit_status = ST_NO_HEADER;
              end else begin
                phase_next     = PH_HEADER_LINE;
                nuc_count_next = '0;
                valid_run_next = '0;
              end
            end
          end
          PH_HEADER_LINE: begin
            if (info.is_newline) phase_next = PH_SEQUENCE;
          end
          PH_SEQUENCE: begin
            if (info.visible) begin
              case (info.cls)
                CL_A, CL_C, CL_G, CL_T: begin
                  window_next    = {window[WIN_W-3:0], info.cls[1:0]};
                  nuc_count_next = count_inc;
                  valid_run_next = run_inc;
                  if (run_inc >= k_eff) begin
                    emit        = 1'b1;
                    emit_status = ST_KMER;
                    emit_bits   = window_next & kmer_mask;
                  end
                end
                CL_DEGEN: begin
                  nuc_count_next = count_inc;
                  valid_run_next = '0;
                end
                CL_GAP: ;
                default: begin
                  if (line_start && info.is_plus) begin
                    phase_next        = PH_PLUS_LINE;
                    quality_left_next = nuc_count;
                  end else if (warn_enable) begin
                    emit        = 1'b1;
                    emit_status = ST_WARN;
                  end
                end
              endcase
            end
          end
          PH_PLUS_LINE: begin
            if (info.is_newline) begin
              phase_next = (quality_left == '0) ? PH_EXPECT_HEADER : PH_QUALITY;
            end
          end
          PH_QUALITY: begin
            if (info.visible) begin
              quality_left_next = qual_dec;
              if (qual_dec == '0) phase_next = PH_EXPECT_HEADER;
            end
          end
          default: phase_next = PH_EXPECT_HEADER;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_EXPECT_HEADER;
      line_start   <= 1'b1;
      window       <= '0;
      nuc_count    <= '0;
      valid_run    <= '0;
      quality_left <= '0;
      halted       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        line_start   <= line_start_next;
        window       <= window_next;
        nuc_count    <= nuc_count_next;
        valid_run    <= valid_run_next;
        quality_left <= quality_left_next;
        halted       <= halted_next;
        out_valid    <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    // result payload, loaded only with a new result
    if (accept && emit) begin
      result.status     <= emit_status;
      result.kmer_bits  <= emit_bits;
      result.base_count <= out_count(nuc_count_next);
    end
  end

endmodule

// ----- src/fastq_kmer_extractor_core.sv -----
// top level of the fastq k-mer extractor: config registers and handshakes
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  ------------------------------------------------------------------------
//  input     in         in_valid / in_ready    char_byte, end_of_file
//  result    out        out_valid / out_ready  status, kmer_bits, base_count
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one byte per cycle unless stalled: a byte is decoded and folded into the
//  record state in the cycle it is taken, its result (if any) shows in the
//  next cycle from the result register
//  the input is taken whenever the result register is empty or being drained
//  in the same cycle; while a result waits unread the input stalls
//  synchronous reset restores k = 31, warnings on, and an empty record state
//  config writes are always taken (cfg_ready tied high); unknown indexes drop
//
module fastq_kmer_extractor_core (
  input  logic                       clk,
  input  logic                       rst,
  // byte stream
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 char_byte,
  input  logic                       end_of_file,
  // results
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  output logic [63:0]                kmer_bits,
  output logic [15:0]                base_count,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fkx_pkg::CIDX_W-1:0] cfg_index,
  input  logic [fkx_pkg::KLEN_W-1:0] cfg_data
);
  import fkx_pkg::*;

  logic [KLEN_W-1:0] kmer_length;
  logic              warn_enable;
  char_info_t        info;
  result_t           result;
  logic              in_accept;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KLEN_W'(31);
      warn_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KMER_LENGTH: kmer_length <= cfg_data;
        REG_WARN_ENABLE: warn_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a byte moves in when the result slot is free or empties this cycle
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  fkx_classify u_classify (
    .char_byte (char_byte),
    .info      (info)
  );

  fkx_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .end_of_file (end_of_file),
    .info        (info),
    .kmer_length (kmer_length),
    .warn_enable (warn_enable),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .result      (result)
  );

  // result transaction payload
  assign status     = result.status;
  assign kmer_bits  = result.kmer_bits;
  assign base_count = result.base_count;

endmodule
